/* hw/rtl/websocket_frame_deframer_macros.svh */
// ----------------------------------------------------------------------------
// websocket_frame_deframer_macros.svh
// Assertion macros used by the checker file of the deframer.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/wsd_pkg.sv */
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned LEN_W = 64;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    kind_t      result_kind;
    logic       last_of_frame;
  } result_t;

endpackage

/* hw/rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses received WebSocket frames one byte per cycle. Each accepted byte
// passes an input register and a combinational parser step; a byte that
// yields a result word loads the result register, and a new byte is
// accepted every cycle as long as the result register drains. The rate is
// set by the header/length/mask state update. A mask bit that does not
// match act_as_server yields one error word; every later byte is then
// consumed silently until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [3:0] frame_opcode,
  output logic [1:0] result_kind,
  output logic       last_of_frame
);

  import wsd_pkg::*;

  logic       act_as_server;
  logic       full;
  logic       step;
  logic [7:0] byte_q;
  logic       has_result;
  result_t    result;
  result_t    result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      act_as_server <= 1'b0;
    end else if (cfg_wr_en) begin
      act_as_server <= cfg_wr_data;
    end
  end

  assign step = full && (!out_valid || out_ready);

  wsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .step     (step),
    .full     (full),
    .byte_q   (byte_q)
  );

  wsd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .byte_q        (byte_q),
    .act_as_server (act_as_server),
    .has_result    (has_result),
    .result        (result)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && has_result),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign payload_byte  = result_q.payload_byte;
  assign frame_opcode  = result_q.frame_opcode;
  assign result_kind   = result_q.result_kind;
  assign last_of_frame = result_q.last_of_frame;

endmodule

/* hw/rtl/wsd_in_stage.sv */
// ----------------------------------------------------------------------------
// wsd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       step,
  output logic       full,
  output logic [7:0] byte_q
);

  logic full_next;

  assign in_ready = !full || step;

  always_comb begin
    full_next = full;
    if (in_valid && in_ready) begin
      full_next = 1'b1;
    end else if (step) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

/* hw/rtl/wsd_parser.sv */
// ----------------------------------------------------------------------------
// wsd_parser
// Frame state machine: header, extended length, mask key and payload unmasking.
// ----------------------------------------------------------------------------
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       byte_q,
  input  logic             act_as_server,
  output logic             has_result,
  output wsd_pkg::result_t result
);

  import wsd_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       opcode, opcode_next;
  logic [3:0]       ext_left, ext_left_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [31:0]      mask_key, mask_key_next;
  logic [1:0]       mask_pos, mask_pos_next;
  logic             halted, halted_next;

  always_comb begin
    logic       after_len;
    logic [6:0] len7;
    logic [7:0] key_byte;

    phase_next     = phase;
    opcode_next    = opcode;
    ext_left_next  = ext_left;
    remaining_next = remaining;
    mask_key_next  = mask_key;
    mask_pos_next  = mask_pos;
    halted_next    = halted;
    has_result     = 1'b0;
    result         = '{payload_byte: 8'd0, frame_opcode: opcode,
                       result_kind: KIND_PAYLOAD, last_of_frame: 1'b0};
    after_len      = 1'b0;
    len7           = byte_q[6:0];
    key_byte       = mask_key[8*(3-mask_pos) +: 8];

    if (!halted) begin
      unique case (phase)
        PH_HDR2: begin
          if (byte_q[7] != act_as_server) begin
            has_result           = 1'b1;
            result.result_kind   = KIND_ERROR;
            result.last_of_frame = 1'b1;
            halted_next          = 1'b1;
            phase_next           = PH_HDR1;
          end else if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
            remaining_next = '0;
            ext_left_next  = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            phase_next     = PH_EXT;
          end else begin
            remaining_next = LEN_W'(len7);
            after_len      = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_next = {remaining[LEN_W-9:0], byte_q};
          ext_left_next  = ext_left - 4'd1;
          after_len      = (ext_left_next == 4'd0);
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], byte_q};
          mask_pos_next = mask_pos + 2'd1;
          if (mask_pos == 2'd3) begin
            if (remaining == '0) begin
              has_result           = 1'b1;
              result.result_kind   = KIND_EMPTY;
              result.last_of_frame = 1'b1;
              phase_next           = PH_HDR1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          has_result           = 1'b1;
          result.payload_byte  = act_as_server ? (byte_q ^ key_byte) : byte_q;
          result.last_of_frame = (remaining == LEN_W'(1));
          mask_pos_next        = mask_pos + 2'd1;
          remaining_next       = remaining - LEN_W'(1);
          if (remaining == LEN_W'(1)) begin
            phase_next = PH_HDR1;
          end
        end
        default: begin
          opcode_next    = byte_q[3:0];
          ext_left_next  = 4'd0;
          remaining_next = '0;
          mask_pos_next  = 2'd0;
          phase_next     = PH_HDR2;
        end
      endcase

      if (after_len) begin
        if (act_as_server) begin
          mask_pos_next = 2'd0;
          phase_next    = PH_MASK;
        end else if (remaining_next == '0) begin
          has_result           = 1'b1;
          result.result_kind   = KIND_EMPTY;
          result.last_of_frame = 1'b1;
          phase_next           = PH_HDR1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR1;
      opcode    <= 4'd0;
      ext_left  <= 4'd0;
      remaining <= '0;
      mask_key  <= 32'd0;
      mask_pos  <= 2'd0;
      halted    <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      opcode    <= opcode_next;
      ext_left  <= ext_left_next;
      remaining <= remaining_next;
      mask_key  <= mask_key_next;
      mask_pos  <= mask_pos_next;
      halted    <= halted_next;
    end
  end

endmodule

/* hw/rtl/wsd_out_stage.sv */
// ----------------------------------------------------------------------------
// wsd_out_stage
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wsd_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready,
  output wsd_pkg::result_t result_q
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result;
    end
  end

endmodule

/* hw/rtl/wsd_checker.sv */
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic [3:0] frame_opcode,
  input logic [1:0] result_kind,
  input logic       last_of_frame
);

  import wsd_pkg::*;

  logic        error_word;
  logic        error_taken;
  logic        marker_word;
  logic        closed_empty;
  logic        stalled;
  logic [14:0] word;

  assign error_word   = out_valid && (result_kind == KIND_ERROR);
  assign error_taken  = error_word && out_ready;
  assign marker_word  = out_valid && (result_kind == KIND_EMPTY);
  assign closed_empty = last_of_frame && (payload_byte == 8'd0);
  assign stalled      = out_valid && !out_ready;
  assign word         = {payload_byte, frame_opcode, result_kind, last_of_frame};

  `WSD_ASSERT_NOW(a_error_closes, error_word, closed_empty, "error word not last or not empty")
  `WSD_ASSERT_NOW(a_marker_closes, marker_word, closed_empty, "marker not last or not empty")
  `WSD_ASSERT_NEXT(a_halt_after_error, error_taken, !out_valid, "output after protocol error")
  `WSD_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(word), "stalled word changed")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
